>>> rtl/core/ctb_pkg.sv
// Shared types, constants and access-mode decode for the conflict-based task batcher.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ctb_pkg;

  localparam int SLOT_FIELDS = 4;   // access slots carried by one task
  localparam int RES_ID_W    = 32;
  localparam int MODE_W      = 3;
  localparam int COUNT_W     = 3;
  localparam int BIDX_W      = 16;

  localparam int MAX_ACCESSES_DEF = 4;
  localparam int SET_DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF     = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_DEFAULT = 3'd0,
    MODE_RW      = 3'd1,
    MODE_READ    = 3'd2,
    MODE_WRITE   = 3'd3,
    MODE_NONE    = 3'd4
  } access_mode_t;

  // Per-lane compare results handed to the merge stage
  typedef struct packed {
    logic                   in_set;
    logic [SLOT_FIELDS-1:0] eq_prev;   // id equals that of an earlier slot
  } ctb_lane_res_t;

  typedef struct packed {
    logic               start;
    logic               mt;
    logic [COUNT_W-1:0] count;         // already clamped to the lane count
  } ctb_task_ctl_t;

  typedef struct packed {
    logic [BIDX_W-1:0] batch_index;
    logic              opens_batch;
    logic              batch_multithreaded;
    logic              self_conflict;
    logic              set_overflow;
  } ctb_result_t;

  function automatic logic mode_reads(input logic [MODE_W-1:0] m);
    logic r;
    case (m) inside
      MODE_DEFAULT, MODE_RW, MODE_READ: r = 1'b1;
      default:                          r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic mode_writes(input logic [MODE_W-1:0] m);
    logic w;
    case (m) inside
      MODE_DEFAULT, MODE_RW, MODE_WRITE: w = 1'b1;
      default:                           w = 1'b0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ctb_if.sv
// Valid/ready channel interfaces for task input and batch result output.
// Depends on ctb_pkg for field widths.
`default_nettype none

interface ctb_in_if;
  import ctb_pkg::*;
  logic                valid;
  logic                ready;
  logic                start_build;
  logic                multithreaded;
  logic [COUNT_W-1:0]  access_count;
  logic [RES_ID_W-1:0] res_id_0;
  logic [RES_ID_W-1:0] res_id_1;
  logic [RES_ID_W-1:0] res_id_2;
  logic [RES_ID_W-1:0] res_id_3;
  logic [MODE_W-1:0]   mode_0;
  logic [MODE_W-1:0]   mode_1;
  logic [MODE_W-1:0]   mode_2;
  logic [MODE_W-1:0]   mode_3;

  modport source (
    output valid, start_build, multithreaded, access_count,
           res_id_0, res_id_1, res_id_2, res_id_3, mode_0, mode_1, mode_2, mode_3,
    input  ready
  );
  modport sink (
    input  valid, start_build, multithreaded, access_count,
           res_id_0, res_id_1, res_id_2, res_id_3, mode_0, mode_1, mode_2, mode_3,
    output ready
  );
endinterface

interface ctb_out_if;
  import ctb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BIDX_W-1:0] batch_index;
  logic              opens_batch;
  logic              batch_multithreaded;
  logic              self_conflict;
  logic              set_overflow;

  modport source (
    output valid, batch_index, opens_batch, batch_multithreaded, self_conflict,
           set_overflow,
    input  ready
  );
  modport sink (
    input  valid, batch_index, opens_batch, batch_multithreaded, self_conflict,
           set_overflow,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/ctb_lane.sv
// One access lane: matches its slot's id against the written set and earlier slots.
// Depends on ctb_pkg.
`default_nettype none

module ctb_lane #(
  parameter int NL        = 4,
  parameter int SLOT      = 0,
  parameter int SET_DEPTH = 16,
  parameter int ID_WIDTH  = 32,
  parameter int FW        = 5
) (
  input  logic [ID_WIDTH-1:0] ids_i     [NL],
  input  logic [ID_WIDTH-1:0] entries_i [SET_DEPTH],
  input  logic [FW-1:0]       fill_i,
  output ctb_pkg::ctb_lane_res_t res_o
);
  import ctb_pkg::*;

  logic [SET_DEPTH-1:0] hit;

  // only entries below the fill count hold live ids
  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      hit[i] = (FW'(i) < fill_i) && (entries_i[i] == ids_i[SLOT]);
    end
  end

  always_comb begin
    res_o.in_set  = |hit;
    res_o.eq_prev = '0;
    for (int j = 0; j < NL; j++) begin
      if (j < SLOT) begin
        res_o.eq_prev[j] = (ids_i[j] == ids_i[SLOT]);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ctb_merge.sv
// Merge stage: combines lane results into check and replay passes, owns the written
// set and the batch state. Depends on ctb_pkg.
`default_nettype none

module ctb_merge #(
  parameter int NL        = 4,
  parameter int SET_DEPTH = 16,
  parameter int ID_WIDTH  = 32,
  parameter int FW        = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire_i,
  input  ctb_pkg::ctb_task_ctl_t   ctl_i,
  input  logic [ID_WIDTH-1:0]      ids_i   [NL],
  input  logic [ctb_pkg::MODE_W-1:0] modes_i [NL],
  input  ctb_pkg::ctb_lane_res_t   lres_i  [NL],
  output logic [ID_WIDTH-1:0]      entries_o [SET_DEPTH],
  output logic [FW-1:0]            fill_o,
  output ctb_pkg::ctb_result_t     res_o
);
  import ctb_pkg::*;

  localparam int CW = $clog2(SET_DEPTH + SLOT_FIELDS + 1);
  localparam int IW = $clog2(SET_DEPTH);

  logic [ID_WIDTH-1:0] entries_r [SET_DEPTH];
  logic [ID_WIDTH-1:0] entries_nxt [SET_DEPTH];
  logic [FW-1:0]       fill_r, fill_nxt, fill_eff;
  logic                open_r, thr_r;
  logic [BIDX_W-1:0]   cnt_r, cnt_nxt;

  logic [NL-1:0] rd, wr;
  logic [NL-1:0] ins [2];          // pass 0: check, pass 1: replay into empty set
  logic [CW-1:0] rank [2][NL];
  logic [CW-1:0] nins [2];
  logic [CW-1:0] free_cnt [2];
  logic [1:0]    conf, ovf;
  logic          open_eff, need_new, sel;
  logic [CW-1:0] base;
  logic [IW-1:0] widx [NL];

  assign fill_eff = ctl_i.start ? '0 : fill_r;
  assign open_eff = open_r && !ctl_i.start;
  assign free_cnt[0] = CW'(SET_DEPTH) - CW'(fill_eff);
  assign free_cnt[1] = CW'(SET_DEPTH);

  always_comb begin
    for (int s = 0; s < NL; s++) begin
      rd[s] = (COUNT_W'(s) < ctl_i.count) && mode_reads(modes_i[s]);
      wr[s] = (COUNT_W'(s) < ctl_i.count) && mode_writes(modes_i[s]);
    end
  end

  // Slot-ordered passes; a read sees set contents plus earlier recorded writes
  always_comb begin
    logic          hit, dup, rd_hit, is_new;
    logic [CW-1:0] nr;
    for (int p = 0; p < 2; p++) begin
      ins[p]  = '0;
      conf[p] = 1'b0;
      ovf[p]  = 1'b0;
      nr      = '0;
      for (int s = 0; s < NL; s++) begin
        hit    = (p == 0) && lres_i[s].in_set && !ctl_i.start;
        dup    = 1'b0;
        rd_hit = 1'b0;
        for (int j = 0; j < s; j++) begin
          if (wr[j] && lres_i[s].eq_prev[j]) dup = 1'b1;
          if (ins[p][j] && lres_i[s].eq_prev[j]) rd_hit = 1'b1;
        end
        if (rd[s] && (hit || rd_hit)) conf[p] = 1'b1;
        is_new     = wr[s] && !dup && !hit;
        rank[p][s] = nr;
        ins[p][s]  = is_new && (nr < free_cnt[p]);
        if (is_new && !(nr < free_cnt[p])) ovf[p] = 1'b1;
        if (is_new) nr = nr + CW'(1);
      end
      nins[p] = (nr < free_cnt[p]) ? nr : free_cnt[p];
    end
  end

  assign need_new = conf[0] || (open_eff && (ctl_i.mt != thr_r));
  assign sel      = need_new;
  assign base     = sel ? '0 : CW'(fill_eff);

  always_comb begin
    logic [CW-1:0] sum;
    for (int s = 0; s < NL; s++) begin
      sum     = base + rank[sel][s];
      widx[s] = sum[IW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < SET_DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
      for (int s = 0; s < NL; s++) begin
        if (ins[sel][s] && (widx[s] == IW'(i))) entries_nxt[i] = ids_i[s];
      end
    end
  end

  always_comb begin
    logic [CW-1:0] fsum;
    fsum     = base + nins[sel];
    fill_nxt = fsum[FW-1:0];
    if (!open_eff) begin
      cnt_nxt = '0;
    end else if (need_new && (cnt_r != {BIDX_W{1'b1}})) begin
      cnt_nxt = cnt_r + BIDX_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign res_o.batch_index         = cnt_nxt;
  assign res_o.opens_batch         = !open_eff || need_new;
  assign res_o.batch_multithreaded = ctl_i.mt;
  assign res_o.self_conflict       = need_new && conf[1];
  assign res_o.set_overflow        = need_new ? ovf[1] : ovf[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      open_r <= 1'b0;
      thr_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (fire_i) begin
      fill_r <= fill_nxt;
      open_r <= 1'b1;
      thr_r  <= ctl_i.mt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_i) begin
      entries_r <= entries_nxt;
    end
  end

  assign entries_o = entries_r;
  assign fill_o    = fill_r;

endmodule

`default_nettype wire

>>> rtl/core/conflict_based_task_batcher.sv
// Top level of the conflict-based task batcher: input register, access lanes, lane result
// register, merge stage, output register. Depends on ctb_pkg, ctb_if, ctb_lane, ctb_merge.
//
//   port     dir   handshake      carries
//   in_ch    in    valid/ready    one task: build start, threading flag, up to 4 accesses
//   out_ch   out   valid/ready    one result per task: batch index and flags
//
// The lanes match the task's ids against the written set, then the merge stage resolves
// the passes and updates the set. The lane stage takes no new task until the merge fires.
// The set update of one task must land before the next task's lane compare.
// Results leave in task order; the input register takes the next task meanwhile.
// rst_n is synchronous; it empties the pipeline and the written set (fill count 0).
// A stalled out_ch holds its result and backs up into the merge and lane stages.
`default_nettype none

module conflict_based_task_batcher #(
  parameter int MAX_ACCESSES = ctb_pkg::MAX_ACCESSES_DEF,
  parameter int SET_DEPTH    = ctb_pkg::SET_DEPTH_DEF,
  parameter int ID_WIDTH     = ctb_pkg::ID_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ctb_in_if.sink         in_ch,
  ctb_out_if.source      out_ch
);
  import ctb_pkg::*;

  localparam int NL = (MAX_ACCESSES < SLOT_FIELDS) ? MAX_ACCESSES : SLOT_FIELDS;
  localparam int FW = $clog2(SET_DEPTH + 1);

  logic [RES_ID_W-1:0] in_ids   [SLOT_FIELDS];
  logic [MODE_W-1:0]   in_modes [SLOT_FIELDS];
  logic [COUNT_W-1:0]  in_count;

  logic                s0_valid_r;
  ctb_task_ctl_t       s0_ctl_r;
  logic [ID_WIDTH-1:0] s0_ids_r   [NL];
  logic [MODE_W-1:0]   s0_modes_r [NL];

  logic                s1_valid_r;
  ctb_task_ctl_t       s1_ctl_r;
  logic [ID_WIDTH-1:0] s1_ids_r   [NL];
  logic [MODE_W-1:0]   s1_modes_r [NL];
  ctb_lane_res_t       s1_lres_r  [NL];

  logic                out_valid_r;
  ctb_result_t         out_res_r;

  ctb_lane_res_t       lres [NL];
  logic [ID_WIDTH-1:0] entries [SET_DEPTH];
  logic [FW-1:0]       fill;
  ctb_result_t         mres;

  logic in_take, advance, merge_fire;

  assign in_ids[0]   = in_ch.res_id_0;
  assign in_ids[1]   = in_ch.res_id_1;
  assign in_ids[2]   = in_ch.res_id_2;
  assign in_ids[3]   = in_ch.res_id_3;
  assign in_modes[0] = in_ch.mode_0;
  assign in_modes[1] = in_ch.mode_1;
  assign in_modes[2] = in_ch.mode_2;
  assign in_modes[3] = in_ch.mode_3;
  assign in_count    = (in_ch.access_count > COUNT_W'(NL)) ? COUNT_W'(NL)
                                                           : in_ch.access_count;

  assign merge_fire  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign advance     = s0_valid_r && !s1_valid_r;
  assign in_ch.ready = !s0_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_take) begin
      s0_valid_r <= 1'b1;
    end else if (advance) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_ctl_r.start <= in_ch.start_build;
      s0_ctl_r.mt    <= in_ch.multithreaded;
      s0_ctl_r.count <= in_count;
      for (int s = 0; s < NL; s++) begin
        s0_ids_r[s]   <= ID_WIDTH'(in_ids[s]);
        s0_modes_r[s] <= in_modes[s];
      end
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    ctb_lane #(
      .NL        (NL),
      .SLOT      (g),
      .SET_DEPTH (SET_DEPTH),
      .ID_WIDTH  (ID_WIDTH),
      .FW        (FW)
    ) u_lane (
      .ids_i     (s0_ids_r),
      .entries_i (entries),
      .fill_i    (fill),
      .res_o     (lres[g])
    );
  end

  // Lane result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= 1'b1;
    end else if (merge_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctl_r   <= s0_ctl_r;
      s1_ids_r   <= s0_ids_r;
      s1_modes_r <= s0_modes_r;
      s1_lres_r  <= lres;
    end
  end

  ctb_merge #(
    .NL        (NL),
    .SET_DEPTH (SET_DEPTH),
    .ID_WIDTH  (ID_WIDTH),
    .FW        (FW)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire_i    (merge_fire),
    .ctl_i     (s1_ctl_r),
    .ids_i     (s1_ids_r),
    .modes_i   (s1_modes_r),
    .lres_i    (s1_lres_r),
    .entries_o (entries),
    .fill_o    (fill),
    .res_o     (mres)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_fire) begin
      out_res_r <= mres;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.batch_index         = out_res_r.batch_index;
  assign out_ch.opens_batch         = out_res_r.opens_batch;
  assign out_ch.batch_multithreaded = out_res_r.batch_multithreaded;
  assign out_ch.self_conflict       = out_res_r.self_conflict;
  assign out_ch.set_overflow        = out_res_r.set_overflow;

endmodule

`default_nettype wire

>>> rtl/core/ctb_checker.sv
// Port-level checks on the batcher's result channel, bound to the top level.
// Depends on ctb_pkg and conflict_based_task_batcher.
`default_nettype none

module ctb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ctb_pkg::BIDX_W-1:0] out_batch_index,
  input logic                       out_opens_batch,
  input logic                       out_batch_mt,
  input logic                       out_self_conflict,
  input logic                       out_set_overflow
);
  import ctb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_batch_index) && $stable(out_opens_batch)
      && $stable(out_batch_mt) && $stable(out_self_conflict) && $stable(out_set_overflow))
    else $error("stalled result changed");

  // a task can only conflict with itself after the set was cleared for it
  a_self_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_self_conflict |-> out_opens_batch)
    else $error("self conflict on a task that did not open a batch");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind conflict_based_task_batcher ctb_checker u_ctb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_batch_index   (out_ch.batch_index),
  .out_opens_batch   (out_ch.opens_batch),
  .out_batch_mt      (out_ch.batch_multithreaded),
  .out_self_conflict (out_ch.self_conflict),
  .out_set_overflow  (out_ch.set_overflow)
);

`default_nettype wire
